>>> rtl/rotation_matrix_to_quaternion_macros.svh
// assertion macros for the rotation matrix to quaternion block
// used by rtl/rotation_matrix_to_quaternion.sv, no other dependencies
`ifndef ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH
`define ROTATION_MATRIX_TO_QUATERNION_MACROS_SVH

// same-cycle implication, disabled in reset
`define RMQ_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled in reset
`define RMQ_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/rmq_pkg.sv
// types and constants for the rotation matrix to quaternion block
// no dependencies
`timescale 1ns / 1ps

package rmq_pkg;

    localparam int QBITS = 16;                  // result magnitude search bits
    localparam int WIDE = 54;                   // width of the square compares
    localparam int TW = 19;                     // signed diagonal sum width
    localparam int MAGW = 18;                   // numerator magnitude width
    localparam logic signed [TW-1:0] ONE_Q14 = 19'sd16384;
    localparam logic [QBITS:0] Q_MAX = 17'd32768;
    localparam int LANES = 4;

    typedef struct packed {
        logic signed [15:0] m00;
        logic signed [15:0] m01;
        logic signed [15:0] m02;
        logic signed [15:0] m10;
        logic signed [15:0] m11;
        logic signed [15:0] m12;
        logic signed [15:0] m20;
        logic signed [15:0] m21;
        logic signed [15:0] m22;
    } mat_t;

    typedef struct packed {
        logic signed [15:0] quat_w;
        logic signed [15:0] quat_x;
        logic signed [15:0] quat_y;
        logic signed [15:0] quat_z;
        logic               bad_matrix;
    } quat_t;

    // one component's search state as it moves down the cell chain
    typedef struct packed {
        logic [QBITS-1:0] q;
        logic [WIDE-1:0]  a;     // q*q*t
        logic [WIDE-1:0]  b;     // q*t
        logic [WIDE-1:0]  lim;   // 4*x*x
        logic             neg;
    } lane_t;

endpackage

>>> rtl/rmq_front.sv
// branch select, numerators and squared limits, two register stages
// depends on rmq_pkg
`timescale 1ns / 1ps

module rmq_front (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          adv,
    input  logic          mat_valid,
    input  rmq_pkg::mat_t mat,
    output logic          valid,
    output logic          bad,
    output logic [16:0]   t,
    output rmq_pkg::lane_t lanes [rmq_pkg::LANES]
);
    import rmq_pkg::*;

    logic                 s1_valid_reg;
    logic signed [TW-1:0] s1_t_reg;
    logic signed [TW-1:0] s1_n_reg [LANES];
    logic signed [TW-1:0] s1_t_next;
    logic signed [TW-1:0] s1_n_next [LANES];

    logic                 s2_valid_reg;
    logic                 s2_bad_reg;
    logic [16:0]          s2_t_reg;
    lane_t                s2_lane_reg [LANES];

    logic signed [TW-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22, tr;

    always_comb
    begin
        e00 = TW'(mat.m00); e01 = TW'(mat.m01); e02 = TW'(mat.m02);
        e10 = TW'(mat.m10); e11 = TW'(mat.m11); e12 = TW'(mat.m12);
        e20 = TW'(mat.m20); e21 = TW'(mat.m21); e22 = TW'(mat.m22);
        tr = e00 + e11 + e22;
        // lanes ordered w, x, y, z
        priority if (tr > 0)
        begin
            s1_t_next = tr + ONE_Q14;
            s1_n_next[0] = s1_t_next;
            s1_n_next[1] = e12 - e21;
            s1_n_next[2] = e20 - e02;
            s1_n_next[3] = e01 - e10;
        end
        else if (e00 > e11 && e00 > e22)
        begin
            s1_t_next = e00 - e11 - e22 + ONE_Q14;
            s1_n_next[0] = e12 - e21;
            s1_n_next[1] = s1_t_next;
            s1_n_next[2] = e01 + e10;
            s1_n_next[3] = e20 + e02;
        end
        else if (e11 > e22)
        begin
            s1_t_next = -e00 + e11 - e22 + ONE_Q14;
            s1_n_next[0] = e20 - e02;
            s1_n_next[1] = e01 + e10;
            s1_n_next[2] = s1_t_next;
            s1_n_next[3] = e12 + e21;
        end
        else
        begin
            s1_t_next = -e00 - e11 + e22 + ONE_Q14;
            s1_n_next[0] = e01 - e10;
            s1_n_next[1] = e20 + e02;
            s1_n_next[2] = e12 + e21;
            s1_n_next[3] = s1_t_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= mat_valid;
            s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_t_reg <= s1_t_next;
            s1_n_reg <= s1_n_next;
            s2_bad_reg <= (s1_t_reg <= 0);
            s2_t_reg <= s1_t_reg[16:0];
            for (int i = 0; i < LANES; i++)
            begin
                logic signed [TW-1:0] n;
                logic [MAGW-1:0]      mag;
                logic [2*MAGW-1:0]    sq;
                n = s1_n_reg[i];
                mag = n[TW-1] ? MAGW'(-n) : MAGW'(n);
                sq = mag * mag;
                s2_lane_reg[i].q <= '0;
                s2_lane_reg[i].a <= '0;
                s2_lane_reg[i].b <= '0;
                s2_lane_reg[i].lim <= WIDE'({sq, 14'b0});
                s2_lane_reg[i].neg <= n[TW-1];
            end
        end
    end

    assign valid = s2_valid_reg;
    assign bad = s2_bad_reg;
    assign t = s2_t_reg;
    assign lanes = s2_lane_reg;

endmodule

>>> rtl/rmq_cell.sv
// one bit of the rounded x/sqrt(t) search, greedy from the top bit down
// depends on rmq_pkg
`timescale 1ns / 1ps

module rmq_cell #(
    parameter int BIT = 15
) (
    input  logic           clk,
    input  logic           adv,
    input  logic [16:0]    t,
    input  rmq_pkg::lane_t lane_in,
    output rmq_pkg::lane_t lane_out
);
    import rmq_pkg::*;

    lane_t           lane_reg;
    lane_t           lane_next;
    logic [WIDE-1:0] tw, an, bn, lhs;
    logic [QBITS-1:0] qt;
    logic            ok;

    always_comb
    begin
        tw = WIDE'(t);
        qt = lane_in.q | (QBITS'(1) << BIT);
        // trial q' = q + 2^BIT, terms kept incrementally by shifts
        an = lane_in.a + (lane_in.b << (BIT + 1)) + (tw << (2 * BIT));
        bn = lane_in.b + (tw << BIT);
        // (2q'-1)^2 t = 4q'^2 t - 4q' t + t
        lhs = (an << 2) + tw - (bn << 2);
        ok = ({1'b0, qt} <= Q_MAX) && (lhs <= lane_in.lim);
        lane_next = lane_in;
        if (ok)
        begin
            lane_next.q = qt;
            lane_next.a = an;
            lane_next.b = bn;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            lane_reg <= lane_next;
    end

    assign lane_out = lane_reg;

endmodule

>>> rtl/rotation_matrix_to_quaternion.sv
// rotation matrix to quaternion, top level: front end, 16 cell chain, output register
// depends on rmq_pkg, rmq_front, rmq_cell and the macros header
//
//  channel | valid      | stall      | payload
//  input   | mat_valid  | mat_stall  | mat  (mat_t)
//  output  | quat_valid | quat_stall | quat (quat_t)
//
// one item per cycle while the output is not stalled; two front stages, one cell per result bit, output reg
// the 16 cell chain of the rounded reciprocal square root sets the latency
// reset clears all valid bits; payload registers are not reset
// a stalled output freezes the whole pipe, and the input is stalled in that cycle
`timescale 1ns / 1ps
`include "rotation_matrix_to_quaternion_macros.svh"

module rotation_matrix_to_quaternion (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           mat_valid,
    output logic           mat_stall,
    input  rmq_pkg::mat_t  mat,
    output logic           quat_valid,
    input  logic           quat_stall,
    output rmq_pkg::quat_t quat
);
    import rmq_pkg::*;

    logic        adv;
    logic        v_reg [QBITS];
    logic        bad_reg [QBITS];
    logic [16:0] t_reg [QBITS];
    logic        f_valid, f_bad;
    logic [16:0] f_t;
    lane_t       chain [QBITS+1][LANES];
    logic        out_valid_reg;
    quat_t       out_reg, out_next;
    logic [15:0] res [LANES];

    assign adv = !(out_valid_reg && quat_stall);
    assign mat_stall = !adv;

    rmq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .adv       (adv),
        .mat_valid (mat_valid),
        .mat       (mat),
        .valid     (f_valid),
        .bad       (f_bad),
        .t         (f_t),
        .lanes     (chain[0])
    );

    for (genvar s = 0; s < QBITS; s++)
    begin : g_stage
        for (genvar l = 0; l < LANES; l++)
        begin : g_lane
            rmq_cell #(.BIT(QBITS - 1 - s)) u_cell (
                .clk      (clk),
                .adv      (adv),
                .t        ((s == 0) ? f_t : t_reg[(s == 0) ? 0 : s - 1]),
                .lane_in  (chain[s][l]),
                .lane_out (chain[s+1][l])
            );
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int s = 0; s < QBITS; s++)
                v_reg[s] <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            v_reg[0] <= f_valid;
            for (int s = 1; s < QBITS; s++)
                v_reg[s] <= v_reg[s-1];
            out_valid_reg <= v_reg[QBITS-1];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            t_reg[0] <= f_t;
            bad_reg[0] <= f_bad;
            for (int s = 1; s < QBITS; s++)
            begin
                t_reg[s] <= t_reg[s-1];
                bad_reg[s] <= bad_reg[s-1];
            end
            out_reg <= out_next;
        end
    end

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            // negate, or saturate a positive 32768; a bad matrix forces zero
            if (chain[QBITS][l].neg)
                res[l] = -chain[QBITS][l].q;
            else if ({1'b0, chain[QBITS][l].q} == Q_MAX)
                res[l] = 16'h7fff;
            else
                res[l] = chain[QBITS][l].q;
            if (bad_reg[QBITS-1])
                res[l] = '0;
        end
        out_next.quat_w = res[0];
        out_next.quat_x = res[1];
        out_next.quat_y = res[2];
        out_next.quat_z = res[3];
        out_next.bad_matrix = bad_reg[QBITS-1];
    end

    assign quat_valid = out_valid_reg;
    assign quat = out_reg;

    `RMQ_ASSERT_NOW(a_bad_zero, quat_valid && quat.bad_matrix, quat.quat_w == 0 && quat.quat_x == 0 && quat.quat_y == 0 && quat.quat_z == 0, "bad matrix with nonzero quaternion")
    `RMQ_ASSERT_NOW(a_stall_link, 1'b1, mat_stall == (quat_valid && quat_stall), "input stall not tied to output stall")
    `RMQ_ASSERT_NEXT(a_accept_enters, mat_valid && !mat_stall, u_front.s1_valid_reg, "accepted item lost at front")
    `RMQ_ASSERT_NEXT(a_hold_out, quat_valid && quat_stall, quat_valid && $stable(quat), "stalled result changed")

endmodule

>>> dv/tb_rotation_matrix_to_quaternion.sv
// testbench for the rotation matrix to quaternion block: random and corner matrices
// depends on rmq_pkg and rtl/rotation_matrix_to_quaternion.sv
`timescale 1ns / 1ps

module tb_rotation_matrix_to_quaternion;
    import rmq_pkg::*;

    class quat_scoreboard;
        quat_t pending[$];
        int mismatches;
        int checked;
        int bad_seen;
        int branch_hits[4];

        // round-half-up of x/sqrt(t), capped at 32768
        function automatic int unsigned root_quotient(longint unsigned x, longint unsigned t);
            longint unsigned lim;
            longint unsigned d;
            int unsigned lo;
            int unsigned hi;
            int unsigned mid;
            lo = 0;
            hi = 32768;
            lim = 4 * x * x;
            while (lo < hi) begin
                mid = (lo + hi + 1) / 2;
                d = 2 * longint'(mid) - 1;
                if (d * d * t <= lim)
                    lo = mid;
                else
                    hi = mid - 1;
            end
            return lo;
        endfunction

        function automatic logic signed [15:0] scaled_component(int n, int t);
            int unsigned r;
            longint unsigned mag;
            mag = (n < 0) ? longint'(-n) : longint'(n);
            r = root_quotient(64 * mag, t);
            if (n < 0)
                return 16'(-int'(r));
            return (r > 32767) ? 16'sd32767 : 16'(r);
        endfunction

        function void note_matrix(mat_t m);
            int a00, a01, a02, a10, a11, a12, a20, a21, a22;
            int t, nw, nx, ny, nz, br;
            quat_t q;
            a00 = m.m00; a01 = m.m01; a02 = m.m02;
            a10 = m.m10; a11 = m.m11; a12 = m.m12;
            a20 = m.m20; a21 = m.m21; a22 = m.m22;
            if (a00 + a11 + a22 > 0) begin
                br = 0;
                t = a00 + a11 + a22 + 16384;
                nw = t; nz = a01 - a10; ny = a20 - a02; nx = a12 - a21;
            end else if (a00 > a11 && a00 > a22) begin
                br = 1;
                t = a00 - a11 - a22 + 16384;
                nx = t; ny = a01 + a10; nz = a20 + a02; nw = a12 - a21;
            end else if (a11 > a22) begin
                br = 2;
                t = -a00 + a11 - a22 + 16384;
                ny = t; nx = a01 + a10; nw = a20 - a02; nz = a12 + a21;
            end else begin
                br = 3;
                t = -a00 - a11 + a22 + 16384;
                nz = t; nw = a01 - a10; nx = a20 + a02; ny = a12 + a21;
            end
            branch_hits[br]++;
            q = '0;
            if (t <= 0) begin
                q.bad_matrix = 1'b1;
                bad_seen++;
            end else begin
                q.quat_w = scaled_component(nw, t);
                q.quat_x = scaled_component(nx, t);
                q.quat_y = scaled_component(ny, t);
                q.quat_z = scaled_component(nz, t);
            end
            pending.push_back(q);
        endfunction

        function void check_quat(quat_t got);
            quat_t want;
            if (pending.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected item: %h", got);
                return;
            end
            want = pending.pop_front();
            checked++;
            if (got.quat_w !== want.quat_w || got.quat_x !== want.quat_x ||
                got.quat_y !== want.quat_y || got.quat_z !== want.quat_z ||
                got.bad_matrix !== want.bad_matrix) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("mismatch: want w=%0d x=%0d y=%0d z=%0d bad=%b, got w=%0d x=%0d y=%0d z=%0d bad=%b",
                             want.quat_w, want.quat_x, want.quat_y, want.quat_z,
                             want.bad_matrix, got.quat_w, got.quat_x, got.quat_y,
                             got.quat_z, got.bad_matrix);
            end
        endfunction
    endclass

    localparam int LATENCY = 19;
    localparam int CYCLE_LIMIT = 200000;

    logic  clk;
    logic  rst_n;
    logic  mat_valid;
    logic  mat_stall;
    mat_t  mat;
    logic  quat_valid;
    logic  quat_stall;
    quat_t quat;

    quat_scoreboard board;
    bit    calm;          // no idling on either side
    int    cycles;
    bit    timed_out;

    rotation_matrix_to_quaternion dut (
        .clk(clk),
        .rst_n(rst_n),
        .mat_valid(mat_valid),
        .mat_stall(mat_stall),
        .mat(mat),
        .quat_valid(quat_valid),
        .quat_stall(quat_stall),
        .quat(quat)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial begin
        board = new();
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT && !timed_out) begin
            timed_out = 1;
            $display("timeout after %0d cycles", cycles);
            $display("rotation_matrix_to_quaternion regression: fail");
            $finish;
        end
    end

    // results are checked at the rising edge
    always @(posedge clk) begin
        if (rst_n && quat_valid && !quat_stall)
            board.check_quat(quat);
    end

    always @(negedge clk) begin
        if (!rst_n)
            quat_stall <= 1'b0;
        else
            quat_stall <= calm ? 1'b0 : ($urandom_range(99) < 13);
    end

    // valid stays high between back to back items and drops only while idling
    task automatic send_matrix(mat_t m);
        while (!calm && $urandom_range(99) < 13) begin
            mat_valid <= 1'b0;
            @(negedge clk);
        end
        mat <= m;
        mat_valid <= 1'b1;
        @(posedge clk);
        while (mat_stall) @(posedge clk);
        board.note_matrix(m);
        @(negedge clk);
    endtask

    function automatic mat_t random_rotation_like();
        mat_t m;
        logic signed [15:0] d[3];
        int pick;
        m = $bits(mat_t)'({$urandom, $urandom, $urandom, $urandom, $urandom});
        pick = $urandom_range(3);
        // mostly near-unit elements so every branch and t range is reached
        if ($urandom_range(99) < 75) begin
            m.m00 = 16'($signed($urandom_range(32768)) - 16384);
            m.m01 = 16'($signed($urandom_range(32768)) - 16384);
            m.m02 = 16'($signed($urandom_range(32768)) - 16384);
            m.m10 = 16'($signed($urandom_range(32768)) - 16384);
            m.m11 = 16'($signed($urandom_range(32768)) - 16384);
            m.m12 = 16'($signed($urandom_range(32768)) - 16384);
            m.m20 = 16'($signed($urandom_range(32768)) - 16384);
            m.m21 = 16'($signed($urandom_range(32768)) - 16384);
            m.m22 = 16'($signed($urandom_range(32768)) - 16384);
            if (pick != 0) begin
                // chosen largest diagonal, the other two not positive; the trace may still be positive
                d[0] = -16'($urandom_range(16384));
                d[1] = -16'($urandom_range(16384));
                d[2] = -16'($urandom_range(16384));
                d[pick-1] = 16'($urandom_range(16384));
                m.m00 = d[0]; m.m11 = d[1]; m.m22 = d[2];
            end
        end
        return m;
    endfunction

    function automatic mat_t diag_matrix(int a, int b, int c, int off);
        mat_t m;
        m.m00 = 16'(a); m.m11 = 16'(b); m.m22 = 16'(c);
        m.m01 = 16'(off); m.m02 = 16'(-off); m.m10 = 16'(-off);
        m.m12 = 16'(off); m.m20 = 16'(off); m.m21 = 16'(-off);
        return m;
    endfunction

    initial begin
        calm = 0;
        rst_n = 1'b0;
        mat_valid = 1'b0;
        mat = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: identity, the three half-turns, ties, extremes
        send_matrix(diag_matrix(16384, 16384, 16384, 0));
        send_matrix(diag_matrix(16384, -16384, -16384, 0));
        send_matrix(diag_matrix(-16384, 16384, -16384, 0));
        send_matrix(diag_matrix(-16384, -16384, 16384, 0));
        send_matrix(diag_matrix(-8192, -8192, -8192, 5000));
        send_matrix(diag_matrix(0, 0, 0, 0));
        send_matrix(diag_matrix(1, 0, -1, 0));
        send_matrix(diag_matrix(32767, 32767, 32767, 32767));
        send_matrix(diag_matrix(32767, 32767, 32767, -32768));
        send_matrix(diag_matrix(-32768, -32768, -32768, 32767));
        send_matrix(diag_matrix(32767, -32768, -32768, -32768));
        send_matrix(diag_matrix(-32768, 32767, -32768, 32767));
        send_matrix(diag_matrix(-32768, -32768, 32767, 1));
        send_matrix(diag_matrix(-1, -32768, 32767, 0));
        send_matrix(diag_matrix(0, -32768, 0, 0));
        send_matrix(diag_matrix(1, -16384, -16384, 100));
        send_matrix(diag_matrix(-16384, -16384, -16384, 0));
        send_matrix(diag_matrix(-16385, -1, 0, 0));
        send_matrix('1);
        send_matrix({9{16'h8000}});
        send_matrix({9{16'h7fff}});
        send_matrix({9{16'h5555}});
        send_matrix({9{16'haaaa}});
        mat_valid <= 1'b0;

        // sender holds off until everything has drained
        while (board.pending.size() != 0) @(posedge clk);
        @(negedge clk);

        for (int i = 0; i < 1600; i++) begin
            calm = (i >= 600 && i < 800);
            send_matrix(random_rotation_like());
        end
        mat_valid <= 1'b0;
        calm = 0;

        while (board.pending.size() != 0) @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);

        $display("checked %0d quaternions, %0d flagged bad; branches trace/x/y/z: %0d %0d %0d %0d",
                 board.checked, board.bad_seen, board.branch_hits[0],
                 board.branch_hits[1], board.branch_hits[2], board.branch_hits[3]);
        $display("%0d mismatches", board.mismatches);
        if (board.mismatches == 0 && board.pending.size() == 0)
            $display("rotation_matrix_to_quaternion regression: pass");
        else
            $display("rotation_matrix_to_quaternion regression: fail");
        $finish;
    end

endmodule
